// File: sv/aes128_block_encrypt_core_defines.svh
// Assertion macros shared by the AES-128 encrypt core.
`ifndef AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_CORE_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define AES_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define AES_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/aes128_pkg.sv
// Types, constants and round functions for the AES-128 encrypt core.
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic [7:0] SboxAffine = 8'h63;
  localparam logic [7:0] PolyReduce = 8'h1b;
  localparam logic [7:0] RconLast   = 8'h36;

  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;

  typedef logic [127:0] block_t;
  typedef logic [NumRounds:0][127:0] rk_array_t;
  typedef logic [3:0] round_idx_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? PolyReduce : 8'h00);
  endfunction

  // Round constant for expansion step n (1..10)
  function automatic logic [7:0] rcon(input round_idx_t n);
    logic [7:0] r;
    r = 8'h01;
    case (n)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = PolyReduce;
      4'd10:   r = RconLast;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]; byte 4c+r is row r, column c
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

// File: sv/aes128_key_expand.sv
// Key registers and sequential round-key expansion, one round key a cycle until a key write restarts it.
module aes128_key_expand
  import aes128_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data,
  output rk_array_t  round_keys,
  output logic       busy
);

  logic [63:0] key_high, key_low;
  block_t      cur;
  round_idx_t  cnt;
  logic [31:0] t, n0, n1, n2, n3;
  // round keys 1..10 held at index 0..9
  block_t      rk [NumRounds];

  assign cfg_ready = 1'b1;

  always_comb begin
    t  = sub_word({cur[23:0], cur[31:24]}) ^ {rcon(cnt), 24'h0};
    n0 = cur[127:96] ^ t;
    n1 = cur[95:64] ^ n0;
    n2 = cur[63:32] ^ n1;
    n3 = cur[31:0] ^ n2;
  end

  always_comb begin
    round_keys[0] = {key_high, key_low};
    for (int i = 1; i <= NumRounds; i++) begin
      round_keys[i] = rk[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      cur      <= '0;
      cnt      <= 4'd1;
      busy     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegKeyHigh) begin
        key_high <= cfg_data;
        cur      <= {cfg_data, key_low};
        cnt      <= 4'd1;
        busy     <= 1'b1;
      end else if (cfg_index == RegKeyLow) begin
        key_low  <= cfg_data;
        cur      <= {key_high, cfg_data};
        cnt      <= 4'd1;
        busy     <= 1'b1;
      end
    end else if (busy) begin
      cur <= {n0, n1, n2, n3};
      rk[cnt - 4'd1] <= {n0, n1, n2, n3};
      cnt <= cnt + 4'd1;
      if (cnt == round_idx_t'(NumRounds)) busy <= 1'b0;
    end
  end

endmodule

// File: sv/aes128_round.sv
// One registered AES round stage with its own valid bit and back-pressure.
module aes128_round
  import aes128_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   mix_en,
  input  block_t round_key,
  input  logic   in_valid,
  output logic   in_ready,
  input  block_t in_state,
  output logic   out_valid,
  input  logic   out_ready,
  output block_t out_state
);

  block_t ss;

  assign ss       = sub_shift(in_state);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_state <= (mix_en ? mix_columns(ss) : ss) ^ round_key;
    end
  end

endmodule

// File: sv/aes128_block_encrypt_core.sv
// AES-128 encrypt core: key expansion plus an eleven-stage round pipeline.
//
// Encrypts one 128-bit block per item with AES-128 (FIPS-197). The pipeline
// is fully unrolled: a whitening stage adding round key 0, then ten round
// stages, each one register deep; a new item is accepted every cycle unless
// stage 0 stalls or the key schedule is busy. Each stage has its own valid
// bit and stalls only when full and its successor is not ready, so output
// back-pressure fills bubbles first. Round key 0 is the key register pair;
// keys 1..10 are ten registers that a sequencer fills one key a cycle, and
// after reset and after every key register write s_axis_tready is held low
// while the schedule is rebuilt. Write the key only while the core is idle.
// tdata layouts (lowest bit first): s_axis_tdata = plaintext_high [63:0],
// plaintext_low [127:64]; m_axis_tdata = ciphertext_high [63:0],
// ciphertext_low [127:64]. Byte 0 is the most significant byte of each high
// half. Config index 0 = key_high, 1 = key_low; other indexes are ignored.
`include "aes128_block_encrypt_core_defines.svh"
module aes128_block_encrypt_core
  import aes128_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // plaintext_high, plaintext_low
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // ciphertext_high, ciphertext_low
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  rk_array_t round_keys;
  logic      key_busy;
  logic      key_write;

  aes128_key_expand u_key (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (round_keys),
    .busy       (key_busy)
  );

  // accepted write to one of the two key registers
  assign key_write = cfg_valid && cfg_ready &&
                     (cfg_index == RegKeyHigh || cfg_index == RegKeyLow);

  // stage 0: whitening with round key 0
  logic [NumRounds:0] vld;
  logic [NumRounds:0] rdy;
  block_t             st [NumRounds+1];
  logic               ready0;

  assign ready0        = !vld[0] || rdy[1];
  assign s_axis_tready = ready0 && !key_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ready0) begin
      vld[0] <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      st[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ round_keys[0];
    end
  end

  assign rdy[0] = ready0;

  // stages 1..10; the last round skips MixColumns
  for (genvar g = 1; g <= NumRounds; g++) begin : g_round
    logic out_rdy;
    if (g == NumRounds) begin : g_last
      assign out_rdy = m_axis_tready;
    end else begin : g_mid
      assign out_rdy = rdy[g+1];
    end
    aes128_round u_round (
      .clk       (clk),
      .rst       (rst),
      .mix_en    (g != NumRounds),
      .round_key (round_keys[g]),
      .in_valid  (vld[g-1]),
      .in_ready  (rdy[g]),
      .in_state  (st[g-1]),
      .out_valid (vld[g]),
      .out_ready (out_rdy),
      .out_state (st[g])
    );
  end

  assign m_axis_tvalid = vld[NumRounds];
  assign m_axis_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};

  // no item enters while the round keys are being rebuilt
  `AES_ASSERT_SAME(a_no_accept_busy, s_axis_tready, !key_busy)
  // a key write restarts the schedule
  `AES_ASSERT_NEXT(a_cfg_restarts, key_write, key_busy)
  // an accepted item always lands in the whitening stage
  `AES_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, vld[0])

endmodule
